// ===== src/pmf_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the per-pixel temporal median block
// no dependencies; used by the interfaces, controller, datapath and top level
package pmf_pkg;

    localparam int MAX_FRAMES = 16;
    localparam int SAMPLE_W   = 16;
    localparam int CFG_W      = 5;
    localparam int NUM_CH     = 3;
    localparam int POS_W      = $clog2(MAX_FRAMES);
    localparam int CNT_W      = $clog2(MAX_FRAMES + 1);

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [CFG_W-1:0]    cfg_word_t;

    typedef enum logic [0:0] {
        ST_COLLECT,
        ST_SELECT
    } pmf_state_t;

    typedef struct packed {
        logic insert;
        logic load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic last;
    } ctrl_status_t;

endpackage

// ===== src/pmf_if.sv =====
`timescale 1ns / 1ps
// valid/ready channels: input samples, median results, frame count writes
// depends on pmf_pkg
interface pmf_in_if;
    import pmf_pkg::*;
    logic    valid;
    logic    ready;
    sample_t red_sample;
    sample_t green_sample;
    sample_t blue_sample;

    modport source (output valid, output red_sample, output green_sample,
                    output blue_sample, input ready);
    modport sink (input valid, input red_sample, input green_sample,
                  input blue_sample, output ready);
endinterface

interface pmf_out_if;
    import pmf_pkg::*;
    logic    valid;
    logic    ready;
    sample_t red_median;
    sample_t green_median;
    sample_t blue_median;

    modport source (output valid, output red_median, output green_median,
                    output blue_median, input ready);
    modport sink (input valid, input red_median, input green_median,
                  input blue_median, output ready);
endinterface

interface pmf_cfg_if;
    import pmf_pkg::*;
    logic      valid;
    logic      ready;
    cfg_word_t frame_count;

    modport source (output valid, output frame_count, input ready);
    modport sink (input valid, input frame_count, output ready);
endinterface

// ===== src/pmf_ctrl.sv =====
`timescale 1ns / 1ps
// controller: input/output handshake and collect/select sequencing
// depends on pmf_pkg
module pmf_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  pmf_pkg::ctrl_status_t status,
    output pmf_pkg::ctrl_cmd_t    cmd
);
    import pmf_pkg::*;

    pmf_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;

    assign accept = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_COLLECT:
            begin
                if (accept && status.last)
                begin
                    state_next = ST_SELECT;
                end
            end
            ST_SELECT:
            begin
                state_next = ST_COLLECT;
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        cmd.insert = 1'b0;
        cmd.load   = 1'b0;
        case (state_reg)
            ST_COLLECT:
            begin
                // a completing transfer needs the output register free
                in_ready   = !status.last || !out_valid_reg || out_ready;
                cmd.insert = accept;
            end
            ST_SELECT:
            begin
                cmd.load = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_COLLECT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_select_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SELECT |=> state_reg == ST_COLLECT)
        else $error("select state held longer than one cycle");

    a_out_free_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SELECT |-> !out_valid_reg)
        else $error("median loaded over an untaken result");

    a_last_goes_select: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && status.last) |=> state_reg == ST_SELECT)
        else $error("completing transfer did not start selection");

    a_select_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SELECT |=> out_valid_reg)
        else $error("selection did not produce a result");

endmodule

// ===== src/pmf_datapath.sv =====
`timescale 1ns / 1ps
// datapath: frame count register, sorted insertion rows per channel,
// rank select into the output register; depends on pmf_pkg
module pmf_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pmf_pkg::ctrl_cmd_t    cmd,
    output pmf_pkg::ctrl_status_t status,
    input  logic                  cfg_we,
    input  pmf_pkg::cfg_word_t    cfg_data,
    input  pmf_pkg::sample_t      red_sample,
    input  pmf_pkg::sample_t      green_sample,
    input  pmf_pkg::sample_t      blue_sample,
    output pmf_pkg::sample_t      red_median,
    output pmf_pkg::sample_t      green_median,
    output pmf_pkg::sample_t      blue_median
);
    import pmf_pkg::*;

    cfg_word_t              frame_count_reg;
    logic [POS_W-1:0]       frames_seen_reg, frames_seen_next;
    logic [POS_W-1:0]       rank_reg;
    sample_t                sorted_reg  [NUM_CH][MAX_FRAMES];
    sample_t                sorted_next [NUM_CH][MAX_FRAMES];
    sample_t                median_reg  [NUM_CH];
    sample_t                in_vec      [NUM_CH];
    logic [MAX_FRAMES-1:0]  gt          [NUM_CH];
    logic [CNT_W-1:0]       eff_count;
    logic [CNT_W-1:0]       held;

    assign in_vec[0] = red_sample;
    assign in_vec[1] = green_sample;
    assign in_vec[2] = blue_sample;

    // zero acts as one, above the row length acts as the row length
    always_comb
    begin
        if (frame_count_reg == '0)
        begin
            eff_count = CNT_W'(1);
        end
        else if (CNT_W'(frame_count_reg) > CNT_W'(MAX_FRAMES))
        begin
            eff_count = CNT_W'(MAX_FRAMES);
        end
        else
        begin
            eff_count = CNT_W'(frame_count_reg);
        end
    end

    assign held        = CNT_W'(frames_seen_reg) + CNT_W'(1);
    assign status.last = held >= eff_count;

    always_comb
    begin
        frames_seen_next = frames_seen_reg;
        if (cmd.insert)
        begin
            frames_seen_next = status.last ? '0 : held[POS_W-1:0];
        end
    end

    // insertion: entries above the new sample move up one cell
    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            for (int i = 0; i < MAX_FRAMES; i++)
            begin
                gt[c][i] = (POS_W'(i) < frames_seen_reg) && (sorted_reg[c][i] > in_vec[c]);
            end
        end
        for (int c = 0; c < NUM_CH; c++)
        begin
            if (gt[c][0] || frames_seen_reg == '0)
            begin
                sorted_next[c][0] = in_vec[c];
            end
            else
            begin
                sorted_next[c][0] = sorted_reg[c][0];
            end
            for (int i = 1; i < MAX_FRAMES; i++)
            begin
                if (gt[c][i-1])
                begin
                    sorted_next[c][i] = sorted_reg[c][i-1];
                end
                else if (gt[c][i] || POS_W'(i) == frames_seen_reg)
                begin
                    sorted_next[c][i] = in_vec[c];
                end
                else
                begin
                    sorted_next[c][i] = sorted_reg[c][i];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= cfg_word_t'(1);
            frames_seen_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                frame_count_reg <= cfg_data;
            end
            frames_seen_reg <= frames_seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.insert)
        begin
            sorted_reg <= sorted_next;
            rank_reg   <= held[CNT_W-1:1];
        end
        if (cmd.load)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                median_reg[c] <= sorted_reg[c][rank_reg];
            end
        end
    end

    assign red_median   = median_reg[0];
    assign green_median = median_reg[1];
    assign blue_median  = median_reg[2];

endmodule

// ===== src/per_pixel_median_of_frames_core.sv =====
`timescale 1ns / 1ps
// per-pixel temporal median of rgb frames: top level
// depends on pmf_pkg, pmf_if, pmf_ctrl and pmf_datapath
//
// samples: one rgb sample per transfer, one per frame in frame order, for
//   one pixel after another. medians: one rgb result per completed pixel.
// cfg: writes frame_count (0 acts as 1, above 16 acts as 16); write only
//   while the block is idle. cfg.ready is always high.
// each sample is inserted into a sorted row of cells per channel in the
//   cycle it is taken, so samples are taken one per cycle, except in the
//   select state and while a completing sample stalls. the transfer that
//   completes a pixel moves the controller to the select state, which moves
//   the cell of rank count/2 into the output register; the result is shown
//   from the cycle after the select state.
// a result waits in the output register while medians.ready is low; the
//   samples of the next pixel keep flowing, except its completing sample,
//   which stalls until the pending result is taken.
// reset clears the sample count, the pending result and sets frame_count
//   to 1.
module per_pixel_median_of_frames_core (
    input  logic      clk,
    input  logic      rst_n,
    pmf_in_if.sink    samples,
    pmf_out_if.source medians,
    pmf_cfg_if.sink   cfg
);
    import pmf_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    assign cfg.ready = 1'b1;

    pmf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .in_ready  (samples.ready),
        .out_valid (medians.valid),
        .out_ready (medians.ready),
        .status    (status),
        .cmd       (cmd)
    );

    pmf_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg.valid),
        .cfg_data     (cfg.frame_count),
        .red_sample   (samples.red_sample),
        .green_sample (samples.green_sample),
        .blue_sample  (samples.blue_sample),
        .red_median   (medians.red_median),
        .green_median (medians.green_median),
        .blue_median  (medians.blue_median)
    );

endmodule
